/* rtl/fcre_pkg.sv */
// Shared constants and register indexes for the frame change rate estimator.
`timescale 1ns / 1ps

package fcre_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 1048576;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_ROW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SELECT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_RATE = 3'd5;

    localparam logic [8:0]  THRESHOLD_RST    = 9'd10;
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [12:0] FRAME_WIDTH_MAX  = 13'd4096;
    localparam logic [15:0] WINDOW_MS_RST    = 16'd500;
    localparam logic [7:0]  REFRESH_RATE_RST = 8'd60;

    localparam int unsigned ADDR_FULL_W = 25;
    localparam int unsigned PIX_W       = 24;

    localparam int unsigned NUM_W      = 27;
    localparam int unsigned DEN_W      = 17;
    localparam int unsigned RATE_SCALE = 2000;
    localparam logic [11:0] RATE_MAX   = 12'd4095;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

endpackage

/* rtl/fcre_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module fcre_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fcre_pkg::NUM_W-1:0] num,
    input  logic [fcre_pkg::DEN_W-1:0] den,
    output logic                       done,
    output logic [fcre_pkg::NUM_W-1:0] quotient
);

    localparam int unsigned NW    = fcre_pkg::NUM_W;
    localparam int unsigned DW    = fcre_pkg::DEN_W;
    localparam int unsigned CNT_W = $clog2(NW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   den_reg, den_next;

    logic [DW:0]     rem_sh;
    logic [DW:0]     diff;
    logic            ge;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[NW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        ge        = (rem_sh >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NW);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
            quo_next = {quo_reg[NW-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/frame_change_rate_estimator.sv */
// Frame change rate estimator: top level with double frame buffer and rate control.
//
// Pixel and tick requests are taken one per cycle while in the run state and no end-of-frame
// pixel awaits its result. The frame buffers are two single-port-read memories of MAX_PIXELS
// entries with a registered read; each pixel reads its reference from the front buffer and
// writes itself into the back buffer in the same cycle, and the compare happens in the cycle
// after. A pixel marked end_of_frame stops intake until its result is formed; if the rate
// reading is recomputed, the 27-step serial divider runs first. After reset both buffers are
// zeroed by a clearing pass over all MAX_PIXELS entries during which no request is taken;
// configuration writes are taken at any time. A finished result waits in an output register.
`timescale 1ns / 1ps

module frame_change_rate_estimator #(
    parameter int unsigned MAX_PIXELS = fcre_pkg::MAX_PIXELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fcre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fcre_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [7:0]                      s_chan_a,
    input  logic [7:0]                      s_chan_b,
    input  logic [7:0]                      s_chan_c,
    input  logic                            s_end_of_frame,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_frame_unique,
    output logic                            m_rate_updated,
    output logic [11:0]                     m_rate_estimate,
    output logic [7:0]                      m_rate_shown,
    output logic                            m_at_or_above_refresh
);

    localparam int unsigned AW = $clog2(MAX_PIXELS);
    localparam int unsigned FW = fcre_pkg::ADDR_FULL_W;
    localparam int unsigned PW = fcre_pkg::PIX_W;
    localparam int unsigned NW = fcre_pkg::NUM_W;
    localparam int unsigned DW = fcre_pkg::DEN_W;
    localparam logic [FW-1:0] PIX_LIMIT = FW'(MAX_PIXELS);
    localparam logic [AW-1:0] CLR_LAST  = AW'(MAX_PIXELS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t      state_reg, state_next;

    logic [8:0]  threshold_reg;
    logic        single_row_reg;
    logic [11:0] row_select_reg;
    logic [12:0] frame_width_reg;
    logic [15:0] window_ms_reg;
    logic [7:0]  refresh_rate_reg;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic        front_reg, front_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic        differs_reg, differs_next;
    logic [15:0] unique_count_reg, unique_count_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [11:0] rate_reg, rate_next;
    logic        uniq_flag_reg, uniq_flag_next;
    logic        upd_flag_reg, upd_flag_next;

    logic        p1_valid_reg, p1_valid_next;
    logic        p1_cmp_reg, p1_cmp_next;
    logic        p1_eof_reg, p1_eof_next;
    logic [7:0]  p1_a_reg, p1_b_reg, p1_c_reg;

    logic        m_valid_reg, m_valid_next;
    logic        m_unique_reg, m_unique_next;
    logic        m_updated_reg, m_updated_next;
    logic [11:0] m_estimate_reg, m_estimate_next;
    logic [7:0]  m_shown_reg, m_shown_next;
    logic        m_above_reg, m_above_next;

    logic [PW-1:0] mem0_ram [MAX_PIXELS];
    logic [PW-1:0] mem1_ram [MAX_PIXELS];
    logic [PW-1:0] rd0_reg, rd1_reg;

    logic          accept_in;
    logic          pix_accept;
    logic [12:0]   width_eff;
    logic [FW-1:0] addr_full;
    logic          in_range;
    logic          mem_re, mem_we0, mem_we1;
    logic [AW-1:0] wr_idx;
    logic [PW-1:0] wdata;
    logic [PW-1:0] ref_pix;
    logic [7:0]    d_a, d_b, d_c;
    logic          hit;
    logic          uniq;
    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [NW-1:0] div_quo;
    logic [15:0]   e_eff;
    logic [11:0]   rate_sat;

    function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
        abs_diff = (x > y) ? (x - y) : (y - x);
    endfunction

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_RUN) && !(p1_valid_reg && p1_eof_reg);
    assign accept_in  = s_valid && s_ready;
    assign pix_accept = accept_in && !s_cmd;

    assign width_eff = (frame_width_reg == 13'd0 || frame_width_reg > fcre_pkg::FRAME_WIDTH_MAX)
                     ? fcre_pkg::FRAME_WIDTH_MAX : frame_width_reg;
    assign addr_full = FW'(row_reg) * FW'(width_eff) + FW'(col_reg);
    assign in_range  = (addr_full < PIX_LIMIT);

    assign mem_re  = pix_accept && in_range;
    assign mem_we0 = (state_reg == ST_CLEAR) || (mem_re && front_reg);
    assign mem_we1 = (state_reg == ST_CLEAR) || (mem_re && !front_reg);
    assign wr_idx  = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_full[AW-1:0];
    assign wdata   = (state_reg == ST_CLEAR) ? '0 : {s_chan_a, s_chan_b, s_chan_c};

    assign ref_pix = front_reg ? rd1_reg : rd0_reg;
    assign d_a     = abs_diff(p1_a_reg, ref_pix[23:16]);
    assign d_b     = abs_diff(p1_b_reg, ref_pix[15:8]);
    assign d_c     = abs_diff(p1_c_reg, ref_pix[7:0]);
    assign hit     = p1_valid_reg && p1_cmp_reg
                  && ({1'b0, d_a} >= threshold_reg || {1'b0, d_b} >= threshold_reg
                      || {1'b0, d_c} >= threshold_reg);
    assign uniq    = differs_reg || hit;

    assign e_eff     = (elapsed_reg == 16'd0) ? 16'd1 : elapsed_reg;
    assign div_start = (state_reg == ST_PREP);
    assign div_num   = NW'(NW'(unique_count_reg) * NW'(fcre_pkg::RATE_SCALE)) + NW'(e_eff);
    assign div_den   = {e_eff, 1'b0};
    assign rate_sat  = (div_quo > NW'(fcre_pkg::RATE_MAX)) ? fcre_pkg::RATE_MAX : div_quo[11:0];

    fcre_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (mem_we0) begin
            mem0_ram[wr_idx] <= wdata;
        end
        if (mem_we1) begin
            mem1_ram[wr_idx] <= wdata;
        end
        if (mem_re) begin
            rd0_reg <= mem0_ram[addr_full[AW-1:0]];
            rd1_reg <= mem1_ram[addr_full[AW-1:0]];
        end
    end

    always_comb begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        front_next        = front_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        differs_next      = differs_reg || hit;
        unique_count_next = unique_count_reg;
        elapsed_next      = elapsed_reg;
        rate_next         = rate_reg;
        uniq_flag_next    = uniq_flag_reg;
        upd_flag_next     = upd_flag_reg;
        p1_valid_next     = pix_accept;
        p1_cmp_next       = in_range && (!single_row_reg || row_reg == row_select_reg);
        p1_eof_next       = s_end_of_frame;
        m_valid_next      = m_valid_reg && !m_ready;
        m_unique_next     = m_unique_reg;
        m_updated_next    = m_updated_reg;
        m_estimate_next   = m_estimate_reg;
        m_shown_next      = m_shown_reg;
        m_above_next      = m_above_reg;

        if (accept_in && s_cmd && elapsed_reg != fcre_pkg::COUNT_MAX) begin
            elapsed_next = elapsed_reg + 16'd1;
        end

        if (pix_accept) begin
            if (s_end_of_frame) begin
                col_next = '0;
                row_next = '0;
            end else if (13'(col_reg) + 13'd1 >= width_eff) begin
                col_next = '0;
                row_next = row_reg + 12'd1;
            end else begin
                col_next = col_reg + 12'd1;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == CLR_LAST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (p1_valid_reg && p1_eof_reg) begin
                    uniq_flag_next = uniq;
                    differs_next   = 1'b0;
                    if (uniq) begin
                        front_next = !front_reg;
                        if (unique_count_reg != fcre_pkg::COUNT_MAX) begin
                            unique_count_next = unique_count_reg + 16'd1;
                        end
                    end
                    upd_flag_next = (elapsed_reg >= window_ms_reg);
                    state_next    = (elapsed_reg >= window_ms_reg) ? ST_PREP : ST_FIN;
                end
            end
            ST_PREP: begin
                unique_count_next = '0;
                elapsed_next      = '0;
                state_next        = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    rate_next       = upd_flag_reg ? rate_sat : rate_reg;
                    m_valid_next    = 1'b1;
                    m_unique_next   = uniq_flag_reg;
                    m_updated_next  = upd_flag_reg;
                    m_estimate_next = rate_next;
                    m_shown_next    = (rate_next < {4'd0, refresh_rate_reg})
                                    ? rate_next[7:0] : refresh_rate_reg;
                    m_above_next    = (rate_next >= {4'd0, refresh_rate_reg});
                    state_next      = ST_RUN;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            front_reg        <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            differs_reg      <= 1'b0;
            unique_count_reg <= '0;
            elapsed_reg      <= '0;
            rate_reg         <= '0;
            uniq_flag_reg    <= 1'b0;
            upd_flag_reg     <= 1'b0;
            p1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            threshold_reg    <= fcre_pkg::THRESHOLD_RST;
            single_row_reg   <= 1'b0;
            row_select_reg   <= '0;
            frame_width_reg  <= fcre_pkg::FRAME_WIDTH_RST;
            window_ms_reg    <= fcre_pkg::WINDOW_MS_RST;
            refresh_rate_reg <= fcre_pkg::REFRESH_RATE_RST;
        end else begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            front_reg        <= front_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            differs_reg      <= differs_next;
            unique_count_reg <= unique_count_next;
            elapsed_reg      <= elapsed_next;
            rate_reg         <= rate_next;
            uniq_flag_reg    <= uniq_flag_next;
            upd_flag_reg     <= upd_flag_next;
            p1_valid_reg     <= p1_valid_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    fcre_pkg::CFG_THRESHOLD:    threshold_reg    <= cfg_data[8:0];
                    fcre_pkg::CFG_SINGLE_ROW:   single_row_reg   <= cfg_data[0];
                    fcre_pkg::CFG_ROW_SELECT:   row_select_reg   <= cfg_data[11:0];
                    fcre_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[12:0];
                    fcre_pkg::CFG_WINDOW_MS:    window_ms_reg    <= cfg_data[15:0];
                    fcre_pkg::CFG_REFRESH_RATE: refresh_rate_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
        p1_cmp_reg      <= p1_cmp_next;
        p1_eof_reg      <= p1_eof_next;
        p1_a_reg        <= s_chan_a;
        p1_b_reg        <= s_chan_b;
        p1_c_reg        <= s_chan_c;
        m_unique_reg    <= m_unique_next;
        m_updated_reg   <= m_updated_next;
        m_estimate_reg  <= m_estimate_next;
        m_shown_reg     <= m_shown_next;
        m_above_reg     <= m_above_next;
    end

    assign m_valid               = m_valid_reg;
    assign m_frame_unique        = m_unique_reg;
    assign m_rate_updated        = m_updated_reg;
    assign m_rate_estimate       = m_estimate_reg;
    assign m_rate_shown          = m_shown_reg;
    assign m_at_or_above_refresh = m_above_reg;

    a_front_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(front_reg) |-> $past(p1_valid_reg && p1_eof_reg && state_reg == ST_RUN))
        else $error("buffer swap outside frame end");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |=> state_reg == ST_DIV || state_reg == ST_FIN)
        else $error("divide state left early");

    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PREP |=> elapsed_reg == 16'd0 && unique_count_reg == 16'd0)
        else $error("window not cleared after rate update");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside finish state");

    a_no_clear_intake: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |-> state_reg == ST_RUN && !(mem_we0 && mem_we1))
        else $error("pixel access during buffer clear");

endmodule

/* bench/frame_change_rate_estimator_tb.sv */
// Self-checking bench for the frame change rate estimator: directed cases, random phases, pressure.
`timescale 1ns / 1ps

module frame_change_rate_estimator_tb;

    localparam int unsigned STORE_PIXELS   = 1024;
    localparam int unsigned SETTLE_CYCLES  = 48;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 6000;
    localparam logic [fcre_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic        frm_unique;
        logic        updated;
        logic [11:0] estimate;
        logic [7:0]  shown;
        logic        above;
    } rate_reading_t;

    typedef enum int {
        FRAME_COPY,
        FRAME_NEAR,
        FRAME_ONE_OFF,
        FRAME_RANDOM
    } frame_style_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fcre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [fcre_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic                            s_cmd     = 1'b0;
    logic [7:0]                      s_chan_a  = '0;
    logic [7:0]                      s_chan_b  = '0;
    logic [7:0]                      s_chan_c  = '0;
    logic                            s_end_of_frame = 1'b0;
    logic                            m_valid;
    logic                            m_ready   = 1'b1;
    logic                            m_frame_unique;
    logic                            m_rate_updated;
    logic [11:0]                     m_rate_estimate;
    logic [7:0]                      m_rate_shown;
    logic                            m_at_or_above_refresh;

    // predictor copy of the registers
    int unsigned cfg_thr     = fcre_pkg::THRESHOLD_RST;
    int unsigned cfg_one_row = 0;
    int unsigned cfg_row_sel = 0;
    int unsigned cfg_width   = fcre_pkg::FRAME_WIDTH_RST;
    int unsigned cfg_window  = fcre_pkg::WINDOW_MS_RST;
    int unsigned cfg_refresh = fcre_pkg::REFRESH_RATE_RST;

    // predictor copy of the state
    bit [23:0]   p_store [2][STORE_PIXELS];
    bit          p_front      = 1'b0;
    int unsigned p_col        = 0;
    int unsigned p_row        = 0;
    bit          p_changed    = 1'b0;
    int unsigned p_unique_cnt = 0;
    int unsigned p_elapsed    = 0;
    int unsigned p_rate       = 0;

    rate_reading_t expected_readings[$];

    int send_idle_pct    = 0;
    int recv_stall_pct   = 0;
    int items_sent       = 0;
    int readings_checked = 0;
    int rate_updates     = 0;
    int unique_frames    = 0;
    int mismatches       = 0;
    int idle_cycles      = 0;

    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    frame_change_rate_estimator #(
        .MAX_PIXELS(STORE_PIXELS)
    ) i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_chan_a             (s_chan_a),
        .s_chan_b             (s_chan_b),
        .s_chan_c             (s_chan_c),
        .s_end_of_frame       (s_end_of_frame),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_frame_unique       (m_frame_unique),
        .m_rate_updated       (m_rate_updated),
        .m_rate_estimate      (m_rate_estimate),
        .m_rate_shown         (m_rate_shown),
        .m_at_or_above_refresh(m_at_or_above_refresh)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned eff_width();
        return (cfg_width == 0 || cfg_width > 4096) ? 4096 : cfg_width;
    endfunction

    function automatic int unsigned chan_gap(int unsigned x, int unsigned y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic logic [23:0] ref_at_cursor();
        int unsigned addr;
        addr = p_row * eff_width() + p_col;
        if (addr < STORE_PIXELS) return p_store[p_front][addr];
        return 24'($urandom);
    endfunction

    function automatic logic [7:0] nudge(logic [7:0] v);
        int span;
        int r;
        if (cfg_thr == 0) return 8'($urandom);
        span = (cfg_thr > 256) ? 255 : int'(cfg_thr) - 1;
        r = int'(v) + int'($urandom_range(2 * span)) - span;
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        return 8'(r);
    endfunction

    function automatic logic [7:0] step_by_thr(logic [7:0] v);
        int t;
        t = (cfg_thr > 255) ? 255 : int'(cfg_thr);
        if (int'(v) + t <= 255) return 8'(int'(v) + t);
        if (int'(v) >= t) return 8'(int'(v) - t);
        return 8'd255;
    endfunction

    task automatic predict_item(input bit cmd, input logic [7:0] a, input logic [7:0] b,
                                input logic [7:0] c, input bit eof);
        int unsigned   w;
        int unsigned   addr;
        int unsigned   e;
        int unsigned   q;
        logic [23:0]   refpx;
        rate_reading_t want;
        if (cmd) begin
            if (p_elapsed < 32'hFFFF) p_elapsed++;
            return;
        end
        w = eff_width();
        addr = p_row * w + p_col;
        if (addr < STORE_PIXELS) begin
            if (cfg_one_row == 0 || p_row == cfg_row_sel) begin
                refpx = p_store[p_front][addr];
                if (chan_gap(a, refpx[23:16]) >= cfg_thr || chan_gap(b, refpx[15:8]) >= cfg_thr
                    || chan_gap(c, refpx[7:0]) >= cfg_thr)
                    p_changed = 1'b1;
            end
            p_store[!p_front][addr] = {a, b, c};
        end
        if (p_col + 1 >= w) begin
            p_col = 0;
            p_row = (p_row + 1) & 32'hFFF;
        end else begin
            p_col++;
        end
        if (!eof) return;
        want.frm_unique = p_changed;
        want.updated = 1'b0;
        if (p_changed) begin
            if (p_unique_cnt < 32'hFFFF) p_unique_cnt++;
            p_front = !p_front;
        end
        if (p_elapsed >= cfg_window) begin
            e = (p_elapsed == 0) ? 1 : p_elapsed;
            q = (2000 * p_unique_cnt + e) / (2 * e);
            p_rate = (q > 4095) ? 4095 : q;
            p_unique_cnt = 0;
            p_elapsed = 0;
            want.updated = 1'b1;
        end
        p_changed = 1'b0;
        p_col = 0;
        p_row = 0;
        want.estimate = p_rate[11:0];
        want.shown = (p_rate < cfg_refresh) ? p_rate[7:0] : cfg_refresh[7:0];
        want.above = (p_rate >= cfg_refresh);
        expected_readings.push_back(want);
    endtask

    task automatic send_item(input bit cmd, input logic [7:0] a, input logic [7:0] b,
                             input logic [7:0] c, input bit eof);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_chan_a       <= a;
        s_chan_b       <= b;
        s_chan_c       <= c;
        s_end_of_frame <= eof;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_item(cmd, a, b, c, eof);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic send_frame(input int len, input frame_style_t style, input int tick_pct,
                              input bit close);
        int          hit;
        int          k;
        logic [23:0] base;
        logic [23:0] px;
        hit = $urandom_range(len - 1);
        for (k = 0; k < len; k++) begin
            if (tick_pct > 0 && $urandom_range(99) < tick_pct) send_tick();
            base = ref_at_cursor();
            case (style)
                FRAME_COPY:    px = base;
                FRAME_NEAR:    px = {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
                FRAME_ONE_OFF: px = (k == hit) ? {base[23:16], step_by_thr(base[15:8]),
                                                  base[7:0]} : base;
                default:       px = 24'($urandom);
            endcase
            send_item(1'b0, px[23:16], px[15:8], px[7:0], close && (k == len - 1));
        end
    endtask

    task automatic settle_block();
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // upper data bits beyond the register width are filled with noise
    task automatic write_reg(input logic [fcre_pkg::CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int w);
        logic [fcre_pkg::CFG_DATA_W-1:0] data;
        data = (16'($urandom) << w) | 16'(value);
        s_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            fcre_pkg::CFG_THRESHOLD:    cfg_thr     = 32'(data[8:0]);
            fcre_pkg::CFG_SINGLE_ROW:   cfg_one_row = 32'(data[0]);
            fcre_pkg::CFG_ROW_SELECT:   cfg_row_sel = 32'(data[11:0]);
            fcre_pkg::CFG_FRAME_WIDTH:  cfg_width   = 32'(data[12:0]);
            fcre_pkg::CFG_WINDOW_MS:    cfg_window  = 32'(data[15:0]);
            fcre_pkg::CFG_REFRESH_RATE: cfg_refresh = 32'(data[7:0]);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic randomize_regs();
        int unsigned v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 256;
            2:       v = 511;
            3:       v = 255;
            default: v = $urandom_range(1, 40);
        endcase
        write_reg(fcre_pkg::CFG_THRESHOLD, v, 9);
        write_reg(fcre_pkg::CFG_SINGLE_ROW, ($urandom_range(3) == 0), 1);
        write_reg(fcre_pkg::CFG_ROW_SELECT, ($urandom_range(7) == 0) ? 4095 : $urandom_range(3),
                  12);
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 4096;
            2:       v = 8191;
            default: v = $urandom_range(1, 8);
        endcase
        write_reg(fcre_pkg::CFG_FRAME_WIDTH, v, 13);
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(1, 20);
        endcase
        write_reg(fcre_pkg::CFG_WINDOW_MS, v, 16);
        case ($urandom_range(5))
            0:       v = 0;
            1:       v = 255;
            default: v = $urandom_range(1, 120);
        endcase
        write_reg(fcre_pkg::CFG_REFRESH_RATE, v, 8);
    endtask

    task automatic test_reset_defaults();
        send_item(1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_item(1'b0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_item(1'b0, 8'd9, 8'd9, 8'd9, 1'b0);
        send_item(1'b0, 8'd0, 8'd0, 8'd9, 1'b1);
        send_item(1'b0, 8'd255, 8'd0, 8'd0, 1'b0);
        send_item(1'b0, 8'd0, 8'd10, 8'd0, 1'b1);
        send_tick();
        send_item(1'b0, 8'd0, 8'd255, 8'd255, 1'b0);
        send_item(1'b0, 8'd255, 8'd255, 8'd255, 1'b1);
    endtask

    task automatic test_thresholds();
        settle_block();
        write_reg(fcre_pkg::CFG_THRESHOLD, 0, 9);
        send_frame(2, FRAME_COPY, 0, 1'b1);
        write_reg(fcre_pkg::CFG_THRESHOLD, 256, 9);
        send_frame(2, FRAME_RANDOM, 0, 1'b1);
        write_reg(fcre_pkg::CFG_THRESHOLD, 511, 16);
        send_frame(2, FRAME_RANDOM, 0, 1'b1);
        write_reg(fcre_pkg::CFG_THRESHOLD, 1, 9);
        send_frame(2, FRAME_COPY, 0, 1'b1);
        send_frame(2, FRAME_ONE_OFF, 0, 1'b1);
        write_reg(fcre_pkg::CFG_FRAME_WIDTH, 0, 13);
        send_frame(3, FRAME_ONE_OFF, 0, 1'b1);
        write_reg(fcre_pkg::CFG_FRAME_WIDTH, 8191, 13);
        send_frame(3, FRAME_NEAR, 0, 1'b1);
        write_reg(fcre_pkg::CFG_FRAME_WIDTH, 4096, 13);
        write_reg(fcre_pkg::CFG_REFRESH_RATE, 0, 8);
        write_reg(CFG_UNUSED, 16'hFFFF, 16);
        send_frame(2, FRAME_RANDOM, 0, 1'b1);
    endtask

    task automatic test_single_row();
        int          k;
        logic [23:0] px;
        settle_block();
        write_reg(fcre_pkg::CFG_FRAME_WIDTH, 4, 13);
        write_reg(fcre_pkg::CFG_THRESHOLD, 10, 9);
        write_reg(fcre_pkg::CFG_SINGLE_ROW, 1, 1);
        write_reg(fcre_pkg::CFG_ROW_SELECT, 1, 12);
        for (k = 0; k < 12; k++) begin
            px = (p_row == 1) ? ref_at_cursor() : 24'($urandom);
            send_item(1'b0, px[23:16], px[15:8], px[7:0], k == 11);
        end
        for (k = 0; k < 12; k++) begin
            px = ref_at_cursor();
            if (p_row == 1 && p_col == 2) px = px ^ 24'h800000;
            send_item(1'b0, px[23:16], px[15:8], px[7:0], k == 11);
        end
        write_reg(fcre_pkg::CFG_ROW_SELECT, 4095, 12);
        send_frame(8, FRAME_RANDOM, 0, 1'b1);
        write_reg(fcre_pkg::CFG_SINGLE_ROW, 0, 1);
    endtask

    task automatic test_rate_math();
        settle_block();
        write_reg(fcre_pkg::CFG_THRESHOLD, 0, 9);
        write_reg(fcre_pkg::CFG_WINDOW_MS, 0, 16);
        write_reg(fcre_pkg::CFG_REFRESH_RATE, 255, 8);
        send_frame(1, FRAME_RANDOM, 0, 1'b1);
        settle_block();
        write_reg(fcre_pkg::CFG_WINDOW_MS, 1, 16);
        write_reg(fcre_pkg::CFG_REFRESH_RATE, 0, 8);
        repeat (6) send_frame(1, FRAME_RANDOM, 0, 1'b1);
        send_tick();
        send_frame(1, FRAME_RANDOM, 0, 1'b1);
        settle_block();
        write_reg(fcre_pkg::CFG_WINDOW_MS, 16, 16);
        write_reg(fcre_pkg::CFG_REFRESH_RATE, 63, 8);
        repeat (16) send_tick();
        send_frame(1, FRAME_RANDOM, 0, 1'b1);
        settle_block();
        write_reg(fcre_pkg::CFG_REFRESH_RATE, 64, 8);
        repeat (16) send_tick();
        send_frame(1, FRAME_RANDOM, 0, 1'b1);
    endtask

    task automatic test_pressure();
        settle_block();
        write_reg(fcre_pkg::CFG_THRESHOLD, 8, 9);
        write_reg(fcre_pkg::CFG_FRAME_WIDTH, 2, 13);
        write_reg(fcre_pkg::CFG_WINDOW_MS, 3, 16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_kick <= ~hold_kick;
        repeat (60) send_frame($urandom_range(1, 3), frame_style_t'($urandom_range(3)), 20, 1'b1);
    endtask

    task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_items);
        int start;
        int pick;
        int span;
        settle_block();
        randomize_regs();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < n_items) begin
            pick = $urandom_range(99);
            span = (eff_width() > 8) ? 8 : eff_width();
            if (pick < 75) begin
                send_frame($urandom_range(1, 3 * span), frame_style_t'($urandom_range(3)),
                           10, 1'b1);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, (cfg_window < 28) ? cfg_window + 2 : 30)) send_tick();
            end else if (pick < 92) begin
                send_frame($urandom_range(1, span), frame_style_t'($urandom_range(3)), 0, 1'b0);
            end else begin
                send_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic report_reading(input string what, input rate_reading_t want,
                                  input rate_reading_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected unique=%0b upd=%0b est=%0d shown=%0d above=%0b",
                     what, want.frm_unique, want.updated, want.estimate, want.shown, want.above);
            $display("    got unique=%0b upd=%0b est=%0d shown=%0d above=%0b",
                     got.frm_unique, got.updated, got.estimate, got.shown, got.above);
        end
    endtask

    always @(posedge aclk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_readings
        rate_reading_t got;
        rate_reading_t want;
        if (m_valid === 1'b1 && m_ready === 1'b1) begin
            got = {m_frame_unique, m_rate_updated, m_rate_estimate, m_rate_shown,
                   m_at_or_above_refresh};
            if (expected_readings.size() == 0) begin
                report_reading("reading with none pending", got, got);
            end else begin
                want = expected_readings.pop_front();
                if (got.frm_unique !== want.frm_unique || got.updated !== want.updated
                    || got.estimate !== want.estimate || got.shown !== want.shown
                    || got.above !== want.above)
                    report_reading("reading mismatch", want, got);
            end
            readings_checked++;
            if (got.updated === 1'b1) rate_updates++;
            if (got.frm_unique === 1'b1) unique_frames++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request accepted for %0d cycles, %0d readings pending",
                         idle_cycles, expected_readings.size());
                $display("frame_change_rate_estimator_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_thresholds();
        test_single_row();
        test_rate_math();
        test_pressure();
        run_random_phase(0, 0, 140);
        run_random_phase(61, 0, 140);
        run_random_phase(0, 61, 140);
        run_random_phase(29, 29, 140);
        settle_block();
        $display("covered: %0d requests, %0d readings (%0d unique frames, %0d rate updates)",
                 items_sent, readings_checked, unique_frames, rate_updates);
        $display("thresholds, single row, rate rounding, output hold-off, idle mixes; %0d mismatches",
                 mismatches);
        if (mismatches == 0) begin
            $display("frame_change_rate_estimator_tb: done, clean");
        end else begin
            $display("frame_change_rate_estimator_tb: done, errors");
        end
        $finish;
    end

endmodule
